FILE: hw/rtl/rsm_pkg.sv
// shared constants, types and the exponent table for the row softmax core
package rsm_pkg;

    localparam int MaxRow    = 64;
    localparam int AddrW     = 6;
    localparam int CountW    = 7;
    localparam int SumW      = 23;
    localparam int ValueW    = 16;
    localparam logic [16:0] Log2eQ16 = 17'd94548;

    typedef logic [AddrW-1:0]  addr_t;
    typedef logic [CountW-1:0] count_t;
    typedef logic [SumW-1:0]   sum_t;

    // request from the control sequencer to the divider
    typedef struct packed {
        logic        start;
        logic [16:0] dividend;
        sum_t        divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } div_rsp_t;

    localparam logic [31:0] FracStep [8] = '{
        32'd4283353945, 32'd4271771996, 32'd4248701965, 32'd4202935003,
        32'd4112874773, 32'd3938502376, 32'd3611622603, 32'd3037000500
    };

    // 2^(-f/256) in q1.16, evaluated at elaboration for the constant table
    function automatic logic [16:0] pow2_frac(input logic [7:0] f);
        logic [63:0] acc;
        logic [95:0] prod;
        acc = 64'h1_0000_0000;
        for (int b = 0; b < 8; b++) begin
            if (f[b]) begin
                prod = 96'(acc) * 96'(FracStep[b]) + 96'h8000_0000;
                acc  = 64'(prod >> 32);
            end
        end
        return 17'((acc + 64'd32768) >> 16);
    endfunction

    function automatic logic [16:0] exp_table(input logic [7:0] f);
        logic [16:0] t [256];
        for (int i = 0; i < 256; i++) begin
            t[i] = pow2_frac(8'(i));
        end
        return t[f];
    endfunction

endpackage

FILE: hw/rtl/rsm_div.sv
// radix-2 restoring divider: round((dividend << 16) / divisor), saturated
module rsm_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rsm_pkg::div_req_t req,
    output rsm_pkg::div_rsp_t rsp
);
    import rsm_pkg::*;

    localparam int QW = 34;
    localparam int RW = SumW + 1;

    logic          busy_reg, busy_next;
    logic [5:0]    step_reg, step_next;
    logic [QW-1:0] num_reg, num_next;
    logic [RW-1:0] rem_reg, rem_next;
    sum_t          dvs_reg, dvs_next;
    logic          done_reg, done_next;
    logic [15:0]   quo_reg, quo_next;
    logic [RW:0]   trial;
    logic [RW-1:0] shifted;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        shifted   = {rem_reg[RW-2:0], num_reg[QW-1]};
        trial     = {1'b0, shifted} - {2'b0, dvs_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = 6'(QW);
            // numerator includes the half divisor for round to nearest
            num_next  = 34'({req.dividend, 16'b0}) + 34'(req.divisor >> 1);
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[QW-2:0], ~trial[RW]};
            rem_next = trial[RW] ? shifted : trial[RW-1:0];
            step_next = step_reg - 6'd1;
            if (step_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (dvs_reg == '0)
                    quo_next = '0;
                else if ({num_reg[QW-2:0], ~trial[RW]} > 34'd65535)
                    quo_next = 16'hFFFF;
                else
                    quo_next = 16'({num_reg[QW-2:0], ~trial[RW]});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    a_done_after_step: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && step_reg == 6'd1 && !req.start |=> done_reg)
        else $error("divider missed completion");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held");

endmodule

FILE: hw/rtl/row_softmax_core.sv
// row softmax core: buffers a row, then emits max-shifted softmax per element
// One element is taken per cycle while a row is loaded into a 64-entry
// synchronous memory, the maximum tracked on the way in. After the request
// marked row_end the block makes two passes over the memory: a sum pass (one
// read per cycle, pipelined through the exponent multiplier and table), then
// a divide pass that per element takes one read, the exponent pipeline and a
// 34-step restoring divider, plus the wait for the result to be taken. No
// input is accepted from the end of a row until its last result is taken.
// Elements past 64 are dropped and every result of that row carries overflow.
module row_softmax_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    output logic        ready_in,
    input  logic [15:0] value,
    input  logic        row_end,
    output logic        valid_out,
    input  logic        ready_out,
    output logic [15:0] probability,
    output logic        row_last,
    output logic        overflow
);
    import rsm_pkg::*;

    localparam logic [2:0] StLoad = 3'd0;
    localparam logic [2:0] StSum  = 3'd1;
    localparam logic [2:0] StRd   = 3'd2;
    localparam logic [2:0] StExp  = 3'd3;
    localparam logic [2:0] StDiv  = 3'd4;
    localparam logic [2:0] StOut  = 3'd5;

    logic [ValueW-1:0] mem [MaxRow];
    logic [ValueW-1:0] rd_data_reg;

    logic [2:0]         state_reg, state_next;
    count_t             fill_reg, fill_next;
    logic signed [15:0] max_reg, max_next;
    sum_t               sum_reg, sum_next;
    logic               drop_reg, drop_next;
    count_t             rd_idx_reg, rd_idx_next;
    count_t             out_idx_reg, out_idx_next;
    // sum pipeline valid: read, diff, product
    logic [2:0]         pipe_reg, pipe_next;
    logic [2:0]         ecnt_reg, ecnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [15:0]        prob_reg, prob_next;
    logic               last_reg, last_next;

    logic               mem_we, mem_re;
    addr_t              mem_addr;
    logic [16:0]        diff_reg;
    logic [33:0]        prod_reg;
    logic [16:0]        exp_reg;
    logic [25:0]        t8;
    logic [16:0]        exp_val;
    div_req_t           div_req;
    div_rsp_t           div_rsp;
    logic               accept_in;

    assign accept_in = valid_in && ready_in;
    assign ready_in  = (state_reg == StLoad);

    // exponent datapath: diff -> product -> table lookup and shift
    assign t8 = 26'((prod_reg + 34'd32768) >> 16);
    always_comb
    begin
        if (t8[25:8] >= 18'd17)
            exp_val = '0;
        else
            exp_val = exp_table(t8[7:0]) >> t8[12:8];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= value;
        if (mem_re)
            rd_data_reg <= mem[mem_addr];
        diff_reg <= 17'(max_reg) - 17'($signed(rd_data_reg));
        prod_reg <= 34'(diff_reg) * 34'(Log2eQ16);
        exp_reg  <= exp_val;
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        drop_next      = drop_reg;
        rd_idx_next    = rd_idx_reg;
        out_idx_next   = out_idx_reg;
        pipe_next      = {pipe_reg[1:0], 1'b0};
        ecnt_next      = ecnt_reg;
        out_valid_next = out_valid_reg;
        prob_next      = prob_reg;
        last_next      = last_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = fill_reg[AddrW-1:0];
        div_req.start    = 1'b0;
        div_req.dividend = exp_reg;
        div_req.divisor  = sum_reg;
        // product stage is valid, its exponent is ready combinationally
        if (pipe_reg[2])
            sum_next = sum_reg + SumW'(exp_val);
        case (state_reg)
            StLoad:
            begin
                if (accept_in)
                begin
                    if (fill_reg < count_t'(MaxRow))
                    begin
                        mem_we    = 1'b1;
                        fill_next = fill_reg + 7'd1;
                        if (fill_reg == '0 || $signed(value) > max_reg)
                            max_next = $signed(value);
                    end
                    else
                        drop_next = 1'b1;
                    if (row_end)
                    begin
                        state_next  = StSum;
                        rd_idx_next = '0;
                        sum_next    = '0;
                    end
                end
            end
            StSum:
            begin
                if (rd_idx_reg < fill_reg)
                begin
                    mem_re       = 1'b1;
                    mem_addr     = rd_idx_reg[AddrW-1:0];
                    rd_idx_next  = rd_idx_reg + 7'd1;
                    pipe_next[0] = 1'b1;
                end
                else if (pipe_reg == '0)
                begin
                    state_next   = StRd;
                    out_idx_next = '0;
                end
            end
            StRd:
            begin
                mem_re     = 1'b1;
                mem_addr   = out_idx_reg[AddrW-1:0];
                ecnt_next  = 3'd4;
                state_next = StExp;
            end
            StExp:
            begin
                // wait for read, diff, product, exponent registers
                ecnt_next = ecnt_reg - 3'd1;
                if (ecnt_reg == 3'd1)
                begin
                    div_req.start = 1'b1;
                    state_next    = StDiv;
                end
            end
            StDiv:
            begin
                if (div_rsp.done)
                begin
                    prob_next      = div_rsp.quotient;
                    last_next      = (out_idx_reg + 7'd1 == fill_reg);
                    out_valid_next = 1'b1;
                    state_next     = StOut;
                end
            end
            StOut:
            begin
                if (ready_out)
                begin
                    out_valid_next = 1'b0;
                    if (last_reg)
                    begin
                        state_next = StLoad;
                        fill_next  = '0;
                        max_next   = 16'sh8000;
                        sum_next   = '0;
                        drop_next  = 1'b0;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 7'd1;
                        state_next   = StRd;
                    end
                end
            end
            default:
            begin
                state_next = StLoad;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= StLoad;
            fill_reg      <= '0;
            max_reg       <= 16'sh8000;
            sum_reg       <= '0;
            drop_reg      <= 1'b0;
            rd_idx_reg    <= '0;
            out_idx_reg   <= '0;
            pipe_reg      <= '0;
            ecnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            max_reg       <= max_next;
            sum_reg       <= sum_next;
            drop_reg      <= drop_next;
            rd_idx_reg    <= rd_idx_next;
            out_idx_reg   <= out_idx_next;
            pipe_reg      <= pipe_next;
            ecnt_reg      <= ecnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prob_reg <= prob_next;
        last_reg <= last_next;
    end

    rsm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign valid_out   = out_valid_reg;
    assign probability = prob_reg;
    assign row_last    = last_reg;
    assign overflow    = drop_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= count_t'(MaxRow))
        else $error("fill count beyond capacity");
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == StOut)
        else $error("result valid outside output state");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !ready_in)
        else $error("input accepted while results pending");
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out && ready_out && row_last |=> fill_reg == '0 && !drop_reg)
        else $error("row state not cleared after last result");

endmodule
